[design/cmbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmbp_pkg
// Types and constants shared by the message byte parser modules.
// ----------------------------------------------------------------------------
package cmbp_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam int unsigned COUNT_CAP   = (MAX_PAYLOAD > 2047) ? 2047 : MAX_PAYLOAD;
    localparam logic [10:0] COUNT_MAX   = 11'(COUNT_CAP);

    localparam logic [7:0] BYTE_MARKER = 8'hFF;
    localparam logic [7:0] BYTE_END    = 8'h0A;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_OPTION  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_EARLY   = 3'd4;

    localparam logic [3:0] OPTION_COUNT_RESET = 4'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_message;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [7:0]  token;
        logic [3:0]  option_delta;
        logic [3:0]  option_size;
        logic [63:0] value;
        logic [10:0] payload_count;
        logic        last;
    } out_t;

    typedef struct packed {
        logic push;
        out_t data;
    } beat_t;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_CODE    = 9'b000000010,
        PH_MIDH    = 9'b000000100,
        PH_MIDL    = 9'b000001000,
        PH_TOKEN   = 9'b000010000,
        PH_OPTHDR  = 9'b000100000,
        PH_OPTVAL  = 9'b001000000,
        PH_SKIP    = 9'b010000000,
        PH_PAYLOAD = 9'b100000000
    } phase_t;

endpackage
`default_nettype wire

[design/cmbp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmbp_front
// Byte-serial parse state machine; turns each accepted byte into zero or one
// result beat for the queue.
// ----------------------------------------------------------------------------
module cmbp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire cmbp_pkg::in_t in_data,
    input  wire logic          cfg_we,
    input  wire logic [3:0]    cfg_data,
    output cmbp_pkg::beat_t    beat
);

    cmbp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  option_count_reg;
    logic [3:0]  opt_idx_reg, opt_idx_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [3:0]  delta_reg, delta_next;
    logic [3:0]  length_reg, length_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [10:0] pay_cnt_reg, pay_cnt_next;
    logic [7:0]  b;

    assign b = in_data.byte_value;

    always_comb
    begin
        phase_next      = phase_reg;
        opt_idx_next    = opt_idx_reg;
        bytes_left_next = bytes_left_reg;
        delta_next      = delta_reg;
        length_next     = length_reg;
        acc_next        = acc_reg;
        hdr_next        = hdr_reg;
        pay_cnt_next    = pay_cnt_reg;
        beat            = '0;

        if (accept)
        begin
            if (in_data.start_of_message)
            begin
                opt_idx_next    = '0;
                bytes_left_next = '0;
                delta_next      = '0;
                length_next     = '0;
                acc_next        = '0;
                pay_cnt_next    = '0;
                if (b == cmbp_pkg::BYTE_END)
                begin
                    hdr_next       = '0;
                    beat.push      = 1'b1;
                    beat.data.kind = cmbp_pkg::KIND_EARLY;
                    beat.data.last = 1'b1;
                    phase_next     = cmbp_pkg::PH_IDLE;
                end
                else
                begin
                    hdr_next   = {24'd0, b};
                    phase_next = cmbp_pkg::PH_CODE;
                end
            end
            else if (phase_reg == cmbp_pkg::PH_IDLE)
            begin
                phase_next = cmbp_pkg::PH_IDLE;
            end
            else if (phase_reg == cmbp_pkg::PH_PAYLOAD)
            begin
                beat.push = 1'b1;
                if (b == cmbp_pkg::BYTE_END)
                begin
                    beat.data.kind          = cmbp_pkg::KIND_END;
                    beat.data.payload_count = pay_cnt_reg;
                    beat.data.last          = 1'b1;
                    phase_next              = cmbp_pkg::PH_IDLE;
                end
                else
                begin
                    if (pay_cnt_reg < cmbp_pkg::COUNT_MAX)
                        pay_cnt_next = pay_cnt_reg + 11'd1;
                    beat.data.kind          = cmbp_pkg::KIND_PAYLOAD;
                    beat.data.value         = {56'd0, b};
                    beat.data.payload_count = pay_cnt_next;
                end
            end
            else if (b == cmbp_pkg::BYTE_END)
            begin
                beat.push      = 1'b1;
                beat.data.kind = cmbp_pkg::KIND_EARLY;
                beat.data.last = 1'b1;
                phase_next     = cmbp_pkg::PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    cmbp_pkg::PH_CODE:
                    begin
                        hdr_next   = {hdr_reg[23:0], b};
                        phase_next = cmbp_pkg::PH_MIDH;
                    end
                    cmbp_pkg::PH_MIDH:
                    begin
                        hdr_next   = {hdr_reg[23:0], b};
                        phase_next = cmbp_pkg::PH_MIDL;
                    end
                    cmbp_pkg::PH_MIDL:
                    begin
                        hdr_next   = {hdr_reg[23:0], b};
                        phase_next = cmbp_pkg::PH_TOKEN;
                    end
                    cmbp_pkg::PH_TOKEN:
                    begin
                        beat.push              = 1'b1;
                        beat.data.kind         = cmbp_pkg::KIND_HEADER;
                        beat.data.version      = hdr_reg[31:30];
                        beat.data.msg_type     = hdr_reg[29:28];
                        beat.data.token_length = hdr_reg[27:24];
                        beat.data.code         = hdr_reg[23:16];
                        beat.data.message_id   = hdr_reg[15:0];
                        beat.data.token        = b;
                        opt_idx_next           = '0;
                        phase_next = (option_count_reg == 4'd0) ? cmbp_pkg::PH_SKIP
                                                                : cmbp_pkg::PH_OPTHDR;
                    end
                    cmbp_pkg::PH_OPTHDR:
                    begin
                        delta_next      = b[7:4];
                        length_next     = b[3:0];
                        bytes_left_next = (b[3:0] == 4'd0) ? 4'd0 : b[3:0] - 4'd1;
                        acc_next        = '0;
                        phase_next      = cmbp_pkg::PH_OPTVAL;
                    end
                    cmbp_pkg::PH_OPTVAL:
                    begin
                        acc_next = {acc_reg[55:0], b};
                        if (bytes_left_reg != 4'd0)
                        begin
                            bytes_left_next = bytes_left_reg - 4'd1;
                        end
                        else
                        begin
                            beat.push              = 1'b1;
                            beat.data.kind         = cmbp_pkg::KIND_OPTION;
                            beat.data.option_delta = delta_reg;
                            beat.data.option_size  = length_reg;
                            beat.data.value        = {acc_reg[55:0], b};
                            if ({1'b0, opt_idx_reg} + 5'd1 >= {1'b0, option_count_reg})
                            begin
                                opt_idx_next = '0;
                                phase_next   = cmbp_pkg::PH_SKIP;
                            end
                            else
                            begin
                                opt_idx_next = opt_idx_reg + 4'd1;
                                phase_next   = cmbp_pkg::PH_OPTHDR;
                            end
                        end
                    end
                    cmbp_pkg::PH_SKIP:
                    begin
                        if (b == cmbp_pkg::BYTE_MARKER)
                        begin
                            pay_cnt_next = '0;
                            phase_next   = cmbp_pkg::PH_PAYLOAD;
                        end
                    end
                    default:
                    begin
                        phase_next = cmbp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= cmbp_pkg::PH_IDLE;
            option_count_reg <= cmbp_pkg::OPTION_COUNT_RESET;
            opt_idx_reg      <= '0;
            bytes_left_reg   <= '0;
            delta_reg        <= '0;
            length_reg       <= '0;
            acc_reg          <= '0;
            hdr_reg          <= '0;
            pay_cnt_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            opt_idx_reg    <= opt_idx_next;
            bytes_left_reg <= bytes_left_next;
            delta_reg      <= delta_next;
            length_reg     <= length_next;
            acc_reg        <= acc_next;
            hdr_reg        <= hdr_next;
            pay_cnt_reg    <= pay_cnt_next;
            if (cfg_we)
                option_count_reg <= cfg_data;
        end
    end

endmodule
`default_nettype wire

[design/cmbp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmbp_queue
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module cmbp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cmbp_pkg::beat_t beat,
    input  wire logic            pop,
    output cmbp_pkg::out_t       head,
    output logic                 not_empty,
    output logic                 full
);

    cmbp_pkg::out_t mem_reg [cmbp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(cmbp_pkg::QUEUE_DEPTH));
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = beat.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, beat.push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (beat.push)
            mem_reg[wr_ptr_reg] <= beat.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[design/cmbp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmbp_back
// Output register stage; drains the queue onto the result channel.
// ----------------------------------------------------------------------------
module cmbp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cmbp_pkg::out_t head,
    input  wire logic           not_empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output cmbp_pkg::out_t      out_data
);

    logic           valid_reg, valid_next;
    cmbp_pkg::out_t data_reg;

    assign pop        = not_empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule
`default_nettype wire

[design/coap_message_byte_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// coap_message_byte_parser
// Byte-serial parser for a constrained-protocol message with a one-byte token.
//
// Input channel (in_valid/in_stall/in_data): one message byte per beat, with
// start_of_message marking the first byte. A byte is taken at an edge with
// in_valid high and in_stall low; one byte per cycle while out_stall is low.
// Output channel (out_valid/out_stall/out_data): at most one result beat per
// input byte: header, option, payload byte, message end or early end.
// Each result is queued as its byte is taken, then moved to the output register.
// Throughput: one byte per cycle without stalls, set by the parse state machine.
// A stalled receiver holds out_data; the queue absorbs two more results and
// in_stall then rises until the output register drains.
// cfg_we/cfg_data write option_count (reset 2); the user is to do so only while
// the block is idle; the block itself does not enforce it.
// Reset clears the parser to waiting for a start byte and empties the queue.
// ----------------------------------------------------------------------------
module coap_message_byte_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire cmbp_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output cmbp_pkg::out_t      out_data,
    input  wire logic           cfg_we,
    input  wire logic [3:0]     cfg_data
);

    cmbp_pkg::beat_t beat;
    cmbp_pkg::out_t  head;
    logic            not_empty;
    logic            full;
    logic            pop;
    logic            accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    cmbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .beat     (beat)
    );

    cmbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    cmbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[tb/parse_result_checker.sv]
// ----------------------------------------------------------------------------
// parse_result_checker
// Watches both channels of the message byte parser. Every accepted byte is
// run through a local decoder of the message format, which queues the result
// beat it should produce; every accepted result beat is compared field by
// field against the oldest queued one. Mismatches and stray beats are counted.
// ----------------------------------------------------------------------------
module parse_result_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_stall,
    input  wire cmbp_pkg::in_t  in_data,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  wire cmbp_pkg::out_t out_data,
    input  wire logic           cfg_we,
    input  wire logic [3:0]     cfg_data,
    output int unsigned         failures,
    output int unsigned         pending,
    output int unsigned         results_checked,
    output int unsigned         messages_closed
);

    import cmbp_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    out_t        predicted_results [$];
    logic [3:0]  option_count;
    phase_t      phase;
    logic [3:0]  opt_index;
    logic [3:0]  bytes_left;
    logic [3:0]  cur_delta;
    logic [3:0]  cur_length;
    logic [63:0] opt_value;
    logic [31:0] header_word;
    logic [10:0] pay_count;

    task automatic close_message(input logic [2:0] kind);
        out_t res;
        res = '0;
        res.kind = kind;
        if (kind == KIND_END)
            res.payload_count = pay_count;
        res.last = 1'b1;
        phase = PH_IDLE;
        predicted_results.push_back(res);
    endtask

    task automatic decode_byte(input in_t beat);
        out_t       res;
        logic [7:0] b;
        b = beat.byte_value;
        res = '0;
        if (beat.start_of_message)
        begin
            opt_index = '0;
            bytes_left = '0;
            cur_delta = '0;
            cur_length = '0;
            opt_value = '0;
            header_word = '0;
            pay_count = '0;
            if (b == BYTE_END)
            begin
                close_message(KIND_EARLY);
            end
            else
            begin
                header_word = {24'd0, b};
                phase = PH_CODE;
            end
        end
        else if (phase == PH_IDLE)
        begin
            // stray byte outside a message
        end
        else if (phase == PH_PAYLOAD)
        begin
            if (b == BYTE_END)
            begin
                close_message(KIND_END);
            end
            else
            begin
                if (pay_count < COUNT_MAX)
                    pay_count = pay_count + 11'd1;
                res.kind = KIND_PAYLOAD;
                res.value = {56'd0, b};
                res.payload_count = pay_count;
                predicted_results.push_back(res);
            end
        end
        else if (b == BYTE_END)
        begin
            close_message(KIND_EARLY);
        end
        else
        begin
            case (phase)
                PH_CODE:
                begin
                    header_word = {header_word[23:0], b};
                    phase = PH_MIDH;
                end
                PH_MIDH:
                begin
                    header_word = {header_word[23:0], b};
                    phase = PH_MIDL;
                end
                PH_MIDL:
                begin
                    header_word = {header_word[23:0], b};
                    phase = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    res.kind = KIND_HEADER;
                    res.version = header_word[31:30];
                    res.msg_type = header_word[29:28];
                    res.token_length = header_word[27:24];
                    res.code = header_word[23:16];
                    res.message_id = header_word[15:0];
                    res.token = b;
                    predicted_results.push_back(res);
                    opt_index = '0;
                    phase = (option_count == 4'd0) ? PH_SKIP : PH_OPTHDR;
                end
                PH_OPTHDR:
                begin
                    cur_delta = b[7:4];
                    cur_length = b[3:0];
                    bytes_left = (b[3:0] == 4'd0) ? 4'd0 : b[3:0] - 4'd1;
                    opt_value = '0;
                    phase = PH_OPTVAL;
                end
                PH_OPTVAL:
                begin
                    opt_value = {opt_value[55:0], b};
                    if (bytes_left != 4'd0)
                    begin
                        bytes_left = bytes_left - 4'd1;
                    end
                    else
                    begin
                        res.kind = KIND_OPTION;
                        res.option_delta = cur_delta;
                        res.option_size = cur_length;
                        res.value = opt_value;
                        predicted_results.push_back(res);
                        // count may have been rewritten mid-message
                        if (({1'b0, opt_index} + 5'd1) >= {1'b0, option_count})
                        begin
                            opt_index = '0;
                            phase = PH_SKIP;
                        end
                        else
                        begin
                            opt_index = opt_index + 4'd1;
                            phase = PH_OPTHDR;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (b == BYTE_MARKER)
                    begin
                        pay_count = '0;
                        phase = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    phase = PH_IDLE;
                end
            endcase
        end
    endtask

    function automatic bit field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got, input bit loud);
        if (want === got)
            return 1'b0;
        if (loud)
            $display("    %s: expected %h, got %h", name, want, got);
        return 1'b1;
    endfunction

    task automatic compare_result(input out_t got);
        out_t want;
        bit   loud;
        bit   bad;
        if (predicted_results.size() == 0)
        begin
            if (failures < REPORT_LIMIT)
                $display("unexpected result beat: kind %0d value %h last %b",
                         got.kind, got.value, got.last);
            failures++;
            return;
        end
        want = predicted_results.pop_front();
        loud = (failures < REPORT_LIMIT) && (got !== want);
        if (loud)
            $display("result beat %0d mismatch:", results_checked);
        bad = 1'b0;
        bad |= field_differs("kind", want.kind, got.kind, loud);
        bad |= field_differs("version", want.version, got.version, loud);
        bad |= field_differs("msg_type", want.msg_type, got.msg_type, loud);
        bad |= field_differs("token_length", want.token_length, got.token_length, loud);
        bad |= field_differs("code", want.code, got.code, loud);
        bad |= field_differs("message_id", want.message_id, got.message_id, loud);
        bad |= field_differs("token", want.token, got.token, loud);
        bad |= field_differs("option_delta", want.option_delta, got.option_delta, loud);
        bad |= field_differs("option_size", want.option_size, got.option_size, loud);
        bad |= field_differs("value", want.value, got.value, loud);
        bad |= field_differs("payload_count", want.payload_count, got.payload_count, loud);
        bad |= field_differs("last", want.last, got.last, loud);
        if (bad)
            failures++;
        if (want.kind == KIND_END || want.kind == KIND_EARLY)
            messages_closed++;
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            predicted_results.delete();
            option_count = OPTION_COUNT_RESET;
            phase = PH_IDLE;
            opt_index = '0;
            bytes_left = '0;
            cur_delta = '0;
            cur_length = '0;
            opt_value = '0;
            header_word = '0;
            pay_count = '0;
            failures = 0;
            results_checked = 0;
            messages_closed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result(out_data);
            if (in_valid && !in_stall)
                decode_byte(in_data);
            if (cfg_we)
                option_count = cfg_data;
        end
        pending = predicted_results.size();
    end

endmodule

[tb/tb_coap_message_byte_parser.sv]
// ----------------------------------------------------------------------------
// tb_coap_message_byte_parser
// Drives message bytes into the parser: a short directed set of corner
// messages, then random well-formed and broken messages across a sweep of
// option counts, a count change mid-message and one long payload under a held
// receiver. Result checking lives in parse_result_checker.
// ----------------------------------------------------------------------------
module tb_coap_message_byte_parser;

    import cmbp_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 200;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int          LONG_PAYLOAD   = 1030;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_we;
    logic [3:0]  cfg_data;

    int unsigned failures;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned messages_closed;

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned first_option_end;
    logic [3:0]  opt_count_now = OPTION_COUNT_RESET;
    bit          hold_req = 1'b0;
    in_t         msg_q [$];

    coap_message_byte_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    parse_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending_results),
        .results_checked (results_checked),
        .messages_closed (messages_closed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("tb_coap_message_byte_parser failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall segments, plus one long hold on request
    initial
    begin
        int unsigned seg_len;
        int unsigned stall_level;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                seg_len = $urandom_range(4, 64);
                stall_level = $urandom_range(0, 3);
                repeat (seg_len)
                begin
                    out_stall <= ($urandom_range(0, 3) < stall_level);
                    @(negedge clk);
                end
            end
        end
    end

    function automatic in_t beat_of(input logic [7:0] b, input logic s);
        in_t beat;
        beat.byte_value = b;
        beat.start_of_message = s;
        return beat;
    endfunction

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        if ($urandom_range(0, 15) == 0)
            return BYTE_MARKER;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_END);
        return b;
    endfunction

    function automatic logic [7:0] skip_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_END || b == BYTE_MARKER);
        return b;
    endfunction

    task automatic send_byte(input in_t beat);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= beat;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_range(input int unsigned lo, input int unsigned hi);
        for (int unsigned i = lo; i < hi; i++)
            send_byte(msg_q[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_option_count(input logic [3:0] count);
        cfg_we <= 1'b1;
        cfg_data <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        opt_count_now = count;
    endtask

    // payload_len < 0 picks a random payload size
    task automatic build_message(input bit broken, input int payload_len);
        int unsigned len;
        int unsigned marker_at;
        int unsigned k;
        int          n;
        logic [7:0]  ob;
        msg_q.delete();
        first_option_end = 0;
        msg_q.push_back(beat_of(data_byte(), 1'b1));
        repeat (4) msg_q.push_back(beat_of(data_byte(), 1'b0));
        repeat (opt_count_now)
        begin
            do
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15)
                                                  : $urandom_range(0, 3);
                ob = {4'($urandom_range(0, 15)), 4'(len)};
            end
            while (ob == BYTE_END);
            msg_q.push_back(beat_of(ob, 1'b0));
            repeat ((len == 0) ? 1 : len) msg_q.push_back(beat_of(data_byte(), 1'b0));
            if (first_option_end == 0)
                first_option_end = msg_q.size();
        end
        repeat ($urandom_range(0, 2)) msg_q.push_back(beat_of(skip_byte(), 1'b0));
        marker_at = msg_q.size();
        msg_q.push_back(beat_of(BYTE_MARKER, 1'b0));
        if (payload_len < 0)
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
        else
            n = payload_len;
        repeat (n) msg_q.push_back(beat_of(data_byte(), 1'b0));
        msg_q.push_back(beat_of(BYTE_END, 1'b0));
        if (broken)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // end byte before the payload
                    k = $urandom_range(1, marker_at);
                    msg_q[k] = beat_of(BYTE_END, 1'b0);
                    while (msg_q.size() > k + 1)
                        msg_q.delete(msg_q.size() - 1);
                end
                1:
                begin
                    // cut short, next start mark abandons it
                    k = $urandom_range(1, marker_at);
                    while (msg_q.size() > k)
                        msg_q.delete(msg_q.size() - 1);
                end
                default:
                begin
                    msg_q.delete();
                    repeat ($urandom_range(1, 8))
                        msg_q.push_back(beat_of(8'($urandom_range(0, 255)),
                                                ($urandom_range(0, 7) == 0)));
                end
            endcase
        end
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            build_message(($urandom_range(0, 3) == 0), -1);
            send_range(0, msg_q.size());
        end
    endtask

    initial
    begin
        logic [3:0] sweep [0:5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stray bytes, corner header and options, start-byte end, abandoned message
        msg_q.delete();
        msg_q.push_back(beat_of(8'h33, 1'b0));
        msg_q.push_back(beat_of(BYTE_END, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b1));
        msg_q.push_back(beat_of(8'h00, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b0));
        msg_q.push_back(beat_of(8'h00, 1'b0));
        msg_q.push_back(beat_of(8'hF0, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b0));
        msg_q.push_back(beat_of(8'h02, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b0));
        msg_q.push_back(beat_of(8'h00, 1'b0));
        msg_q.push_back(beat_of(8'h00, 1'b0));
        msg_q.push_back(beat_of(BYTE_MARKER, 1'b0));
        msg_q.push_back(beat_of(8'hFF, 1'b0));
        msg_q.push_back(beat_of(8'h00, 1'b0));
        msg_q.push_back(beat_of(BYTE_END, 1'b0));
        msg_q.push_back(beat_of(BYTE_END, 1'b1));
        msg_q.push_back(beat_of(8'h40, 1'b1));
        msg_q.push_back(beat_of(8'h01, 1'b0));
        msg_q.push_back(beat_of(8'h7F, 1'b1));
        msg_q.push_back(beat_of(BYTE_END, 1'b0));
        send_range(0, msg_q.size());
        drain();

        sweep = '{4'd0, 4'd15, 4'd1, 4'd3, 4'($urandom_range(4, 14)), OPTION_COUNT_RESET};
        for (int i = 0; i < 6; i++)
        begin
            if (opt_count_now == 4'd15)
            begin
                // shrink the option count between two options of one message
                build_message(1'b0, 2);
                send_range(0, first_option_end);
                drain();
                write_option_count(sweep[i]);
                send_range(first_option_end, msg_q.size());
            end
            else
            begin
                write_option_count(sweep[i]);
            end
            run_random(RANDOM_ITEMS / 6);
            drain();
        end

        // long payload drives the count into saturation while the receiver holds off
        build_message(1'b0, LONG_PAYLOAD);
        hold_req = 1'b1;
        send_range(0, msg_q.size());
        drain();

        $display("run covered %0d message bytes over option counts 0 to 15, a count change",
                 items_sent);
        $display("mid-message and a %0d-cycle receiver hold; %0d result beats, %0d messages",
                 HOLD_CYCLES, results_checked, messages_closed);
        if (failures == 0 && pending_results == 0)
            $display("tb_coap_message_byte_parser passed");
        else
            $display("tb_coap_message_byte_parser failed");
        $finish;
    end

endmodule
